// File: rtl/e2h_pkg.sv
// ----------------------------------------------------------------------------
// e2h_pkg
// Shared constants, the arctangent table and the CORDIC gain for the
// equatorial to horizontal conversion core.
// ----------------------------------------------------------------------------
package e2h_pkg;

	// angle and vector formats
	localparam int ANGLE_BITS = 32;
	localparam int STAGES     = 32;
	localparam int FB         = 32;   // vector fraction bits
	localparam int VW         = 40;   // vector component width, signed
	localparam int ZW         = 35;   // internal angle accumulator width, signed

	localparam logic signed [VW-1:0] V_ONE     = VW'(64'sd1 <<< FB);
	localparam logic signed [ZW-1:0] A_HALF    = ZW'(64'sd1 <<< (ANGLE_BITS - 1));
	localparam logic signed [ZW-1:0] A_QUARTER = ZW'(64'sd1 <<< (ANGLE_BITS - 2));

	// register map
	localparam logic REG_LATITUDE = 1'b0;

	// pipeline depth from input transaction to output register
	localparam int DEPTH = 1 + STAGES + 1 + 2 + 2 + 1 + 1 + STAGES + 1 + STAGES + 1;

	// atan(2^-i) in turns, 2^32 per turn
	localparam logic signed [ZW-1:0] ATAN [STAGES] = '{
		35'sd536870912, 35'sd316933406, 35'sd167458907, 35'sd85004756,
		35'sd42667331,  35'sd21354465,  35'sd10679838,  35'sd5340245,
		35'sd2670163,   35'sd1335087,   35'sd667544,    35'sd333772,
		35'sd166886,    35'sd83443,     35'sd41722,     35'sd20861,
		35'sd10430,     35'sd5215,      35'sd2608,      35'sd1304,
		35'sd652,       35'sd326,       35'sd163,       35'sd81,
		35'sd41,        35'sd20,        35'sd10,        35'sd5,
		35'sd3,         35'sd1,         35'sd1,         35'sd0
	};

	// cosine of zero as the rotation lanes produce it (carries the gain)
	function automatic logic signed [VW-1:0] cordic_gain();
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] nx;
		logic signed [ZW-1:0] z;
		x = V_ONE;
		y = '0;
		z = '0;
		for (int i = 0; i < STAGES; i++) begin
			if (!z[ZW-1]) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN[i];
			end
			x = nx;
		end
		return x;
	endfunction

	localparam logic signed [VW-1:0] KC = cordic_gain();

endpackage

// File: rtl/e2h_fmul.sv
// ----------------------------------------------------------------------------
// e2h_fmul
// Two-stage fixed-point multiplier: product shifted right by the fraction
// bits, rounded half away from zero.
// ----------------------------------------------------------------------------
module e2h_fmul (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [e2h_pkg::VW-1:0] a,
	input  logic signed [e2h_pkg::VW-1:0] b,
	output logic signed [e2h_pkg::VW-1:0] p
);
	import e2h_pkg::*;

	logic [VW-1:0]      ua;
	logic [VW-1:0]      ub;
	logic [VW+FB-1:0]   pp_lo_s1;
	logic [2*VW-FB-1:0] pp_hi_s1;
	logic               neg_s1;
	logic [2*VW-1:0]    sum;
	logic [VW-1:0]      rnd;

	// magnitudes
	assign ua = a[VW-1] ? VW'(-a) : VW'(a);
	assign ub = b[VW-1] ? VW'(-b) : VW'(b);

	// stage 1: two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s1 <= ua * ub[FB-1:0];
			pp_hi_s1 <= ua * ub[VW-1:FB];
			neg_s1   <= a[VW-1] ^ b[VW-1];
		end
	end

	// stage 2: combine, round, restore sign
	assign sum = (2*VW)'(pp_lo_s1) + ((2*VW)'(pp_hi_s1) << FB);
	assign rnd = sum[VW+FB-1:FB] + VW'(sum[FB-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? -$signed(rnd) : $signed(rnd);
		end
	end

endmodule

// File: rtl/equatorial_to_horizontal_core.sv
// Throughput: one transaction per cycle; every stage advances together,
// and the whole pipeline holds while the output waits on m_tready.
// Depth is set by three 32-step CORDIC chains plus two multiplier levels.
// Reset: arst_n clears all valid bits and sets latitude to zero.
// ----------------------------------------------------------------------------
// equatorial_to_horizontal_core
// Hour angle and declination to altitude and azimuth, pipelined CORDIC.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] hour_angle, [63:32] declination
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // [31:0] altitude, [63:32] azimuth
);
	import e2h_pkg::*;

	localparam int NL = 3;  // rotation lanes: hour angle, declination, latitude

	logic [31:0]      latitude_q;
	logic             pipe_en;
	logic [DEPTH:1]   vld_s;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LATITUDE) ? latitude_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latitude_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_LATITUDE) begin
			latitude_q <= pwdata;
		end
	end

	// ---------------- flow control ----------------
	assign pipe_en  = m_tready || !m_tvalid;
	assign s_tready = pipe_en;
	assign m_tvalid = vld_s[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (pipe_en) begin
			vld_s <= {vld_s[DEPTH-1:1], s_tvalid};
		end
	end

	// ---------------- rotation lanes ----------------
	logic signed [VW-1:0] rx_s [NL][0:STAGES];
	logic signed [VW-1:0] ry_s [NL][0:STAGES];
	logic signed [ZW-1:0] rz_s [NL][0:STAGES];
	logic                 fl_s [NL][0:STAGES];
	logic [31:0]          ang_in [NL];

	assign ang_in[0] = s_tdata[31:0];
	assign ang_in[1] = s_tdata[63:32];
	assign ang_in[2] = latitude_q;

	for (genvar gl = 0; gl < NL; gl++) begin : g_lane
		logic        flip;
		logic [31:0] fold;

		// fold second and third quadrants onto the right half plane
		assign flip = (ang_in[gl][31:30] == 2'b01) || (ang_in[gl][31:30] == 2'b10);
		assign fold = flip ? (ang_in[gl] ^ 32'h8000_0000) : ang_in[gl];

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rx_s[gl][0] <= V_ONE;
				ry_s[gl][0] <= '0;
				rz_s[gl][0] <= ZW'($signed(fold));
				fl_s[gl][0] <= flip;
			end
		end

		for (genvar gi = 0; gi < STAGES; gi++) begin : g_rot
			always_ff @(posedge clk) begin
				if (pipe_en) begin
					fl_s[gl][gi+1] <= fl_s[gl][gi];
					if (!rz_s[gl][gi][ZW-1]) begin
						rx_s[gl][gi+1] <= rx_s[gl][gi] - (ry_s[gl][gi] >>> gi);
						ry_s[gl][gi+1] <= ry_s[gl][gi] + (rx_s[gl][gi] >>> gi);
						rz_s[gl][gi+1] <= rz_s[gl][gi] - ATAN[gi];
					end else begin
						rx_s[gl][gi+1] <= rx_s[gl][gi] + (ry_s[gl][gi] >>> gi);
						ry_s[gl][gi+1] <= ry_s[gl][gi] - (rx_s[gl][gi] >>> gi);
						rz_s[gl][gi+1] <= rz_s[gl][gi] + ATAN[gi];
					end
				end
			end
		end
	end

	// ---------------- sines and cosines ----------------
	logic signed [VW-1:0] sh_t, ch_t, sd_t, cd_t, sl_t, cl_t;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ch_t <= fl_s[0][STAGES] ? -rx_s[0][STAGES] : rx_s[0][STAGES];
			sh_t <= fl_s[0][STAGES] ? -ry_s[0][STAGES] : ry_s[0][STAGES];
			cd_t <= fl_s[1][STAGES] ? -rx_s[1][STAGES] : rx_s[1][STAGES];
			sd_t <= fl_s[1][STAGES] ? -ry_s[1][STAGES] : ry_s[1][STAGES];
			cl_t <= fl_s[2][STAGES] ? -rx_s[2][STAGES] : rx_s[2][STAGES];
			sl_t <= fl_s[2][STAGES] ? -ry_s[2][STAGES] : ry_s[2][STAGES];
		end
	end

	// ---------------- product terms ----------------
	logic signed [VW-1:0] p_shcd, p_chsl, p_sdcl, p_slsd, p_chcd;
	logic signed [VW-1:0] q_ya, q_xb, q_xc, q_zd, q_ze;
	logic signed [VW-1:0] cd_s1, cd_s2, cl_s1, cl_s2;

	e2h_fmul u_m_shcd (.clk(clk), .en(pipe_en), .a(sh_t), .b(cd_t), .p(p_shcd));
	e2h_fmul u_m_chsl (.clk(clk), .en(pipe_en), .a(ch_t), .b(sl_t), .p(p_chsl));
	e2h_fmul u_m_sdcl (.clk(clk), .en(pipe_en), .a(sd_t), .b(cl_t), .p(p_sdcl));
	e2h_fmul u_m_slsd (.clk(clk), .en(pipe_en), .a(sl_t), .b(sd_t), .p(p_slsd));
	e2h_fmul u_m_chcd (.clk(clk), .en(pipe_en), .a(ch_t), .b(cd_t), .p(p_chcd));

	// keep cos dec and cos lat aligned with the first products
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cd_s1 <= cd_t;
			cd_s2 <= cd_s1;
			cl_s1 <= cl_t;
			cl_s2 <= cl_s1;
		end
	end

	e2h_fmul u_m_ya (.clk(clk), .en(pipe_en), .a(p_shcd), .b(KC),    .p(q_ya));
	e2h_fmul u_m_xb (.clk(clk), .en(pipe_en), .a(p_chsl), .b(cd_s2), .p(q_xb));
	e2h_fmul u_m_xc (.clk(clk), .en(pipe_en), .a(p_sdcl), .b(KC),    .p(q_xc));
	e2h_fmul u_m_zd (.clk(clk), .en(pipe_en), .a(p_slsd), .b(KC),    .p(q_zd));
	e2h_fmul u_m_ze (.clk(clk), .en(pipe_en), .a(p_chcd), .b(cl_s2), .p(q_ze));

	logic signed [VW-1:0] xa_s, ya_s, za_s;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ya_s <= q_ya;
			xa_s <= q_xb - q_xc;
			za_s <= q_zd + q_ze;
		end
	end

	// ---------------- azimuth vectoring ----------------
	logic signed [VW-1:0] vx1_s [0:STAGES];
	logic signed [VW-1:0] vy1_s [0:STAGES];
	logic signed [ZW-1:0] vz1_s [0:STAGES];
	logic                 zr1_s [0:STAGES];
	logic signed [VW-1:0] zk_m;
	logic signed [VW-1:0] zkd_s [2:STAGES];

	e2h_fmul u_m_zk (.clk(clk), .en(pipe_en), .a(za_s), .b(KC), .p(zk_m));

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			zr1_s[0] <= (xa_s == '0) && (ya_s == '0);
			vx1_s[0] <= xa_s[VW-1] ? -xa_s : xa_s;
			vy1_s[0] <= xa_s[VW-1] ? -ya_s : ya_s;
			vz1_s[0] <= xa_s[VW-1] ? A_HALF : '0;
			zkd_s[2] <= zk_m;
		end
	end

	for (genvar gk = 3; gk <= STAGES; gk++) begin : g_zk
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				zkd_s[gk] <= zkd_s[gk-1];
			end
		end
	end

	for (genvar gi = 0; gi < STAGES; gi++) begin : g_vec1
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				zr1_s[gi+1] <= zr1_s[gi];
				if (vy1_s[gi][VW-1]) begin
					vx1_s[gi+1] <= vx1_s[gi] - (vy1_s[gi] >>> gi);
					vy1_s[gi+1] <= vy1_s[gi] + (vx1_s[gi] >>> gi);
					vz1_s[gi+1] <= vz1_s[gi] - ATAN[gi];
				end else begin
					vx1_s[gi+1] <= vx1_s[gi] + (vy1_s[gi] >>> gi);
					vy1_s[gi+1] <= vy1_s[gi] - (vx1_s[gi] >>> gi);
					vz1_s[gi+1] <= vz1_s[gi] + ATAN[gi];
				end
			end
		end
	end

	// ---------------- altitude vectoring ----------------
	logic signed [VW-1:0] vx2_s [0:STAGES];
	logic signed [VW-1:0] vy2_s [0:STAGES];
	logic signed [ZW-1:0] vz2_s [0:STAGES];
	logic                 zr2_s [0:STAGES];
	logic [31:0]          azd_s [0:STAGES];
	logic signed [VW-1:0] r_in;
	logic signed [VW-1:0] zk_in;

	assign r_in  = vx1_s[STAGES];
	assign zk_in = zkd_s[STAGES];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			zr2_s[0] <= (r_in == '0) && (zk_in == '0);
			vx2_s[0] <= r_in[VW-1] ? -r_in : r_in;
			vy2_s[0] <= r_in[VW-1] ? -zk_in : zk_in;
			vz2_s[0] <= r_in[VW-1] ? A_HALF : '0;
			azd_s[0] <= zr1_s[STAGES] ? '0 : vz1_s[STAGES][31:0];
		end
	end

	for (genvar gi = 0; gi < STAGES; gi++) begin : g_vec2
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				zr2_s[gi+1] <= zr2_s[gi];
				azd_s[gi+1] <= azd_s[gi];
				if (vy2_s[gi][VW-1]) begin
					vx2_s[gi+1] <= vx2_s[gi] - (vy2_s[gi] >>> gi);
					vy2_s[gi+1] <= vy2_s[gi] + (vx2_s[gi] >>> gi);
					vz2_s[gi+1] <= vz2_s[gi] - ATAN[gi];
				end else begin
					vx2_s[gi+1] <= vx2_s[gi] + (vy2_s[gi] >>> gi);
					vy2_s[gi+1] <= vy2_s[gi] - (vx2_s[gi] >>> gi);
					vz2_s[gi+1] <= vz2_s[gi] + ATAN[gi];
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic signed [ZW-1:0] alt_raw;
	logic signed [ZW-1:0] alt_sat;

	assign alt_raw = zr2_s[STAGES] ? '0 : vz2_s[STAGES];

	// clamp past the poles
	always_comb begin
		if (alt_raw > A_QUARTER) begin
			alt_sat = A_QUARTER;
		end else if (alt_raw < -A_QUARTER) begin
			alt_sat = -A_QUARTER;
		end else begin
			alt_sat = alt_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			m_tdata <= {azd_s[STAGES], alt_sat[31:0]};
		end
	end

`ifndef SYNTH
	// altitude never leaves the quarter-turn range
	a_alt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sh4000_0000 &&
			$signed(m_tdata[31:0]) >= -32'sh4000_0000))
		else $error("altitude out of range");

	// a stall freezes every valid bit in the pipeline
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	// a zero azimuth vector yields zero azimuth
	a_az_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_en && zr1_s[STAGES]) |=> (azd_s[0] == '0))
		else $error("azimuth not zero for zero vector");
`endif

endmodule
